FILE: design/swm_pkg.sv
// Package for the sliding window maximum core.
// Holds the channel payload types, the back-end state type and shared constants.
package swm_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W = 7;
  localparam int WINDOW_MAX_DEF = 64;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] window_max;
    logic last_window;
  } out_item_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_EXP_RD,
    BS_EXP_CHK,
    BS_DRP_RD,
    BS_DRP_CHK,
    BS_FIN
  } back_state_t;

endpackage

FILE: design/swm_front.sv
// Front end: accepts samples, numbers them within the sequence and decides
// whether each one closes a full window. Uses swm_pkg.
module swm_front #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF,
  parameter int PW = $clog2(2 * WINDOW_MAX),
  parameter int WINW = $clog2(WINDOW_MAX + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [WINW-1:0]      win,
  input  logic                 smp_valid,
  input  swm_pkg::in_item_t    smp_data,
  input  logic                 q_full,
  output logic                 smp_stall,
  output logic                 q_push,
  output logic [PW-1:0]        q_pos,
  output logic                 q_emit
);
  import swm_pkg::*;

  localparam int POS_MOD = 2 * WINDOW_MAX;

  logic [PW-1:0]   pos_cnt;
  logic [PW-1:0]   pos_cnt_next;
  logic [WINW-1:0] seen;
  logic [WINW-1:0] seen_next;

  assign smp_stall = q_full;
  assign q_push = smp_valid && !q_full;

  always_comb begin
    if (pos_cnt == PW'(POS_MOD - 1)) begin
      pos_cnt_next = '0;
    end else begin
      pos_cnt_next = pos_cnt + PW'(1);
    end
    if (seen == WINW'(WINDOW_MAX)) begin
      seen_next = seen;
    end else begin
      seen_next = seen + WINW'(1);
    end
  end

  assign q_pos = pos_cnt;
  assign q_emit = (seen_next >= win);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_cnt <= '0;
      seen <= '0;
    end else if (q_push) begin
      if (smp_data.last_sample) begin
        pos_cnt <= '0;
        seen <= '0;
      end else begin
        pos_cnt <= pos_cnt_next;
        seen <= seen_next;
      end
    end
  end

endmodule

FILE: design/swm_queue.sv
// Two-entry queue between the front end and the back end.
// Generic payload vector; no package dependencies.
module swm_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             valid,
  output logic [WIDTH-1:0] head_data
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  assign full = (fill == 2'd2);
  assign valid = (fill != 2'd0);
  assign head_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: design/swm_back.sv
// Back end: monotonic deque kept as a circular buffer in a single-port-read
// memory, each entry read then checked; holds the result register. Uses swm_pkg.
module swm_back #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF,
  parameter int PW = $clog2(2 * WINDOW_MAX),
  parameter int WINW = $clog2(WINDOW_MAX + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [WINW-1:0]                   win,
  input  logic                              q_valid,
  input  logic signed [swm_pkg::DATA_W-1:0] q_sample,
  input  logic                              q_last,
  input  logic                              q_emit,
  input  logic [PW-1:0]                     q_pos,
  output logic                              q_pop,
  output logic                              res_valid,
  input  logic                              res_stall,
  output swm_pkg::out_item_t                res_data
);
  import swm_pkg::*;

  localparam int POS_MOD = 2 * WINDOW_MAX;
  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = $clog2(WINDOW_MAX + 1);

  back_state_t state;
  back_state_t state_next;

  logic [DATA_W+PW-1:0] mem [WINDOW_MAX];
  logic [DATA_W+PW-1:0] rd_q;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic                 mem_we;

  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic signed [DATA_W-1:0] cur_sample;
  logic                     cur_last;
  logic                     cur_emit;
  logic [PW-1:0]            cur_pos;
  logic signed [DATA_W-1:0] front_val;
  logic                     load_item;
  logic                     front_ld;
  logic                     res_load;

  logic signed [DATA_W-1:0] rd_val;
  logic [PW-1:0]            rd_pos;
  logic [PW:0]              age;
  logic                     expire;
  logic                     smaller;
  logic                     out_blocked;
  logic [PW-1:0]            tail_sum;
  logic [PW-1:0]            end_sum;
  logic [AW-1:0]            head_inc;

  function automatic logic [AW-1:0] wrap_idx(input logic [PW-1:0] s);
    if (s >= PW'(WINDOW_MAX)) begin
      return AW'(s - PW'(WINDOW_MAX));
    end
    return AW'(s);
  endfunction

  assign rd_val = rd_q[DATA_W+PW-1:PW];
  assign rd_pos = rd_q[PW-1:0];

  // age of the front entry, modulo twice the window bound
  always_comb begin
    if (cur_pos >= rd_pos) begin
      age = {1'b0, cur_pos} - {1'b0, rd_pos};
    end else begin
      age = {1'b0, cur_pos} + (PW+1)'(POS_MOD) - {1'b0, rd_pos};
    end
  end

  assign expire = (age >= (PW+1)'(win));
  assign smaller = (rd_val < cur_sample);
  assign out_blocked = cur_emit && res_valid && res_stall;

  assign tail_sum = PW'(head) + PW'(count) - PW'(1);
  assign end_sum = PW'(head) + PW'(count);
  assign head_inc = (head == AW'(WINDOW_MAX - 1)) ? '0 : head + AW'(1);
  assign wr_addr = wrap_idx(end_sum);
  assign rd_addr = (state == BS_DRP_RD) ? wrap_idx(tail_sum) : head;

  always_comb begin
    state_next = state;
    unique case (state)
      BS_IDLE: begin
        if (q_valid) begin
          state_next = (count != '0) ? BS_EXP_RD : BS_FIN;
        end
      end
      BS_EXP_RD: state_next = BS_EXP_CHK;
      BS_EXP_CHK: begin
        if (expire) begin
          state_next = (count == CW'(1)) ? BS_FIN : BS_EXP_RD;
        end else begin
          state_next = BS_DRP_RD;
        end
      end
      BS_DRP_RD: state_next = BS_DRP_CHK;
      BS_DRP_CHK: begin
        if (smaller && count != CW'(1)) begin
          state_next = BS_DRP_RD;
        end else begin
          state_next = BS_FIN;
        end
      end
      BS_FIN: begin
        if (!out_blocked) begin
          state_next = BS_IDLE;
        end
      end
      default: state_next = BS_IDLE;
    endcase
  end

  always_comb begin
    head_next = head;
    count_next = count;
    q_pop = 1'b0;
    load_item = 1'b0;
    front_ld = 1'b0;
    mem_we = 1'b0;
    res_load = 1'b0;
    unique case (state)
      BS_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          load_item = 1'b1;
        end
      end
      BS_EXP_RD: begin
      end
      BS_EXP_CHK: begin
        if (expire) begin
          head_next = head_inc;
          count_next = count - CW'(1);
        end else begin
          front_ld = 1'b1;
        end
      end
      BS_DRP_RD: begin
      end
      BS_DRP_CHK: begin
        if (smaller) begin
          count_next = count - CW'(1);
        end
      end
      BS_FIN: begin
        if (!out_blocked) begin
          mem_we = 1'b1;
          res_load = cur_emit;
          if (cur_last) begin
            head_next = '0;
            count_next = '0;
          end else begin
            count_next = count + CW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= {cur_sample, cur_pos};
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (load_item) begin
      cur_sample <= q_sample;
      cur_last <= q_last;
      cur_emit <= q_emit;
      cur_pos <= q_pos;
    end
    if (front_ld) begin
      front_val <= rd_val;
    end
    // an empty deque at append time means the new sample is the front
    if (res_load) begin
      res_data.window_max <= (count == '0) ? cur_sample : front_val;
      res_data.last_window <= cur_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_IDLE;
      head <= '0;
      count <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      head <= head_next;
      count <= count_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: design/sliding_window_maximum_core.sv
// Top level of the sliding window maximum core: window register, front end,
// queue and back end. Uses swm_pkg, swm_front, swm_queue, swm_back.
//
//  Channel   Signals                        Transfer when
//  smp       smp_valid smp_stall smp_data   smp_valid && !smp_stall
//  res       res_valid res_stall res_data   res_valid && !res_stall
//  cfg       cfg_valid cfg_ready cfg_data   cfg_valid && cfg_ready
//
// In the back end each sample passes BS_IDLE, then a read and a check state per deque
// entry examined (expired, dropped, plus the one that stops each walk), then BS_FIN;
// the single registered read port of the deque memory sets this. The front end and a
// two-entry queue take samples while the back end works. Reset (rst, sync)
// empties the deque and sets the window to 1. A stalled result holds the back end
// only when the next sample has a result of its own.
module sliding_window_maximum_core #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        smp_valid,
  output logic                        smp_stall,
  input  swm_pkg::in_item_t           smp_data,
  output logic                        res_valid,
  input  logic                        res_stall,
  output swm_pkg::out_item_t          res_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [swm_pkg::CFG_W-1:0]   cfg_data
);
  import swm_pkg::*;

  localparam int PW = $clog2(2 * WINDOW_MAX);
  localparam int WINW = $clog2(WINDOW_MAX + 1);
  localparam int QW = DATA_W + 2 + PW;

  logic [CFG_W-1:0] window_size;
  logic [WINW-1:0]  win;

  logic             q_full;
  logic             q_push;
  logic             q_pop;
  logic             q_valid;
  logic [PW-1:0]    f_pos;
  logic             f_emit;
  logic [QW-1:0]    q_in;
  logic [QW-1:0]    q_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      window_size <= cfg_data;
    end
  end

  // zero acts as one, anything above the bound saturates
  always_comb begin
    if (window_size == '0) begin
      win = WINW'(1);
    end else if (32'(window_size) > 32'(WINDOW_MAX)) begin
      win = WINW'(WINDOW_MAX);
    end else begin
      win = WINW'(window_size);
    end
  end

  swm_front #(
    .WINDOW_MAX(WINDOW_MAX),
    .PW(PW),
    .WINW(WINW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .win(win),
    .smp_valid(smp_valid),
    .smp_data(smp_data),
    .q_full(q_full),
    .smp_stall(smp_stall),
    .q_push(q_push),
    .q_pos(f_pos),
    .q_emit(f_emit)
  );

  assign q_in = {smp_data.sample, smp_data.last_sample, f_emit, f_pos};

  swm_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_data(q_in),
    .pop(q_pop),
    .full(q_full),
    .valid(q_valid),
    .head_data(q_out)
  );

  swm_back #(
    .WINDOW_MAX(WINDOW_MAX),
    .PW(PW),
    .WINW(WINW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .win(win),
    .q_valid(q_valid),
    .q_sample(q_out[QW-1:PW+2]),
    .q_last(q_out[PW+1]),
    .q_emit(q_out[PW]),
    .q_pos(q_out[PW-1:0]),
    .q_pop(q_pop),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data(res_data)
  );

endmodule
